// ----- rtl/trrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrm_pkg
// Shared types and codes for the two-run record merge core.
// ----------------------------------------------------------------------------
package trrm_pkg;

	// Request decode: bit 1 selects a pull, bit 0 selects the run on append
	localparam int unsigned REQ_PULL_BIT = 1;
	localparam int unsigned REQ_SIDE_BIT = 0;

	localparam int unsigned NAME_W  = 64;
	localparam int unsigned ID_W    = 32;
	localparam int unsigned OTHER_W = 64;
	localparam int unsigned KEY_W   = 2 * NAME_W + ID_W;

	typedef enum logic [2:0] {
		RS_RECORD   = 3'd0,
		RS_APPENDED = 3'd1,
		RS_EMPTY    = 3'd2,
		RS_FULL     = 3'd3,
		RS_DRAINING = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [NAME_W-1:0]        surname;
		logic [NAME_W-1:0]        given_name;
		logic signed [ID_W-1:0]   person_id;
		logic [OTHER_W-1:0]       other_fields;
	} rec_t;

	typedef struct packed {
		status_t status;
		rec_t    rec;
		logic    last;
	} res_t;

	// Keep bytes up to the first zero byte and within the character limit
	function automatic logic [NAME_W-1:0] norm_name(logic [NAME_W-1:0] v,
			int unsigned nchars);
		logic [NAME_W-1:0] o;
		logic              live;
		o    = '0;
		live = 1'b1;
		for (int unsigned b = 0; b < 8; b++) begin
			if (live && (b < nchars) && (v[NAME_W-1-8*b -: 8] != 8'd0)) begin
				o[NAME_W-1-8*b -: 8] = v[NAME_W-1-8*b -: 8];
			end else begin
				live = 1'b0;
			end
		end
		return o;
	endfunction

	// Sort key: surname, given name, then id with sign bit flipped
	function automatic logic [KEY_W-1:0] rec_key(rec_t r);
		return {r.surname, r.given_name, ~r.person_id[ID_W-1], r.person_id[ID_W-2:0]};
	endfunction

endpackage

// ----- rtl/trrm_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrm_req_if
// Request channel: append to a run or pull the next merged record.
// ----------------------------------------------------------------------------
interface trrm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [63:0]        in_surname;
	logic [63:0]        in_given_name;
	logic signed [31:0] in_person_id;
	logic [63:0]        in_other_fields;

	modport source (
		output valid, req_type, in_surname, in_given_name, in_person_id, in_other_fields,
		input  ready
	);

	modport sink (
		input  valid, req_type, in_surname, in_given_name, in_person_id, in_other_fields,
		output ready
	);
endinterface

// ----- rtl/trrm_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrm_rsp_if
// Response channel: status word and the emitted record.
// ----------------------------------------------------------------------------
interface trrm_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [63:0]        out_surname;
	logic [63:0]        out_given_name;
	logic signed [31:0] out_person_id;
	logic [63:0]        out_other_fields;
	logic               last_of_merge;

	modport source (
		output valid, status, out_surname, out_given_name, out_person_id,
		       out_other_fields, last_of_merge,
		input  ready
	);

	modport sink (
		input  valid, status, out_surname, out_given_name, out_person_id,
		       out_other_fields, last_of_merge,
		output ready
	);
endinterface

// ----- rtl/trrm_run_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrm_run_mem
// Record store for one run: one write port, one registered read port.
// ----------------------------------------------------------------------------
module trrm_run_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  trrm_pkg::rec_t  wdata,
	input  logic [AW-1:0]   raddr,
	output trrm_pkg::rec_t  rdata
);
	import trrm_pkg::*;

	rec_t mem [DEPTH];

	// Write record
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/trrm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrm_ctrl
// Sequencer: appends records, reads both run heads, picks the smaller key,
// tracks fill and pull counts and holds the response register.
// ----------------------------------------------------------------------------
module trrm_ctrl #(
	parameter int unsigned RUN_DEPTH  = 32,
	parameter int unsigned NAME_CHARS = 8,
	parameter int unsigned OTHER_BITS = 64,
	parameter int unsigned AW         = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	trrm_req_if.sink        req,
	trrm_rsp_if.source      rsp,
	output logic            we_a,
	output logic            we_b,
	output logic [AW-1:0]   waddr,
	output trrm_pkg::rec_t  wdata,
	output logic [AW-1:0]   raddr_a,
	output logic [AW-1:0]   raddr_b,
	input  trrm_pkg::rec_t  rdata_a,
	input  trrm_pkg::rec_t  rdata_b
);
	import trrm_pkg::*;

	localparam int unsigned CW = $clog2(RUN_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(RUN_DEPTH);
	localparam logic [AW-1:0] TOP_ADDR = AW'(RUN_DEPTH - 1);
	localparam logic [OTHER_W-1:0] OTHER_MASK = (OTHER_BITS >= OTHER_W) ?
		{OTHER_W{1'b1}} : ((OTHER_W'(1) << OTHER_BITS) - OTHER_W'(1));

	state_t        state_q, state_nx;
	logic [CW-1:0] cnt_a_q, cnt_b_q, tak_a_q, tak_b_q;
	logic          draining_q;
	res_t          res_q;
	res_t          out_q;
	logic          out_valid_q;

	logic          acc, is_pull, side_b, run_full, app_ok;
	logic [CW-1:0] sel_cnt;
	logic          has_a, has_b, from_a, last_pull, out_load;
	logic [CW-1:0] tak_a_nx, tak_b_nx;
	rec_t          rec_sel;

	// Request decode and append path
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		acc       = req.valid && req.ready;
		is_pull   = req.req_type[REQ_PULL_BIT];
		side_b    = req.req_type[REQ_SIDE_BIT];
		sel_cnt   = side_b ? cnt_b_q : cnt_a_q;
		run_full  = (sel_cnt >= DEPTH_C);
		app_ok    = acc && !is_pull && !draining_q && !run_full;
		we_a      = app_ok && !side_b;
		we_b      = app_ok && side_b;
		waddr     = sel_cnt[AW-1:0];
		wdata.surname      = norm_name(req.in_surname, NAME_CHARS);
		wdata.given_name   = norm_name(req.in_given_name, NAME_CHARS);
		wdata.person_id    = req.in_person_id;
		wdata.other_fields = req.in_other_fields & OTHER_MASK;
		raddr_a = (tak_a_q >= DEPTH_C) ? TOP_ADDR : tak_a_q[AW-1:0];
		raddr_b = (tak_b_q >= DEPTH_C) ? TOP_ADDR : tak_b_q[AW-1:0];
	end

	// Head selection once the read data is back
	always_comb begin
		has_a = (tak_a_q < cnt_a_q);
		has_b = (tak_b_q < cnt_b_q);
		if (has_a && has_b) begin
			from_a = (rec_key(rdata_a) < rec_key(rdata_b));
		end else begin
			from_a = has_a;
		end
		rec_sel   = from_a ? rdata_a : rdata_b;
		tak_a_nx  = tak_a_q + CW'(from_a);
		tak_b_nx  = tak_b_q + CW'(!from_a);
		last_pull = (tak_a_nx >= cnt_a_q) && (tak_b_nx >= cnt_b_q);
		out_load  = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_nx = is_pull ? ST_READ : ST_EMIT;
				end
			end
			ST_READ: state_nx = ST_EMIT;
			ST_EMIT: begin
				if (out_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			tak_a_q     <= '0;
			tak_b_q     <= '0;
			draining_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (we_a) begin
				cnt_a_q <= cnt_a_q + CW'(1);
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + CW'(1);
			end
			if ((state_q == ST_READ) && (has_a || has_b)) begin
				if (last_pull) begin
					cnt_a_q    <= '0;
					cnt_b_q    <= '0;
					tak_a_q    <= '0;
					tak_b_q    <= '0;
					draining_q <= 1'b0;
				end else begin
					tak_a_q    <= tak_a_nx;
					tak_b_q    <= tak_b_nx;
					draining_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result and output words
	always_ff @(posedge clk) begin
		if (acc && !is_pull) begin
			res_q.rec  <= '0;
			res_q.last <= 1'b0;
			if (draining_q) begin
				res_q.status <= RS_DRAINING;
			end else if (run_full) begin
				res_q.status <= RS_FULL;
			end else begin
				res_q.status <= RS_APPENDED;
			end
		end else if (state_q == ST_READ) begin
			if (has_a || has_b) begin
				res_q.status <= RS_RECORD;
				res_q.rec    <= rec_sel;
				res_q.last   <= last_pull;
			end else begin
				res_q.status <= RS_EMPTY;
				res_q.rec    <= '0;
				res_q.last   <= 1'b0;
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// Drive response channel
	always_comb begin
		rsp.valid            = out_valid_q;
		rsp.status           = out_q.status;
		rsp.out_surname      = out_q.rec.surname;
		rsp.out_given_name   = out_q.rec.given_name;
		rsp.out_person_id    = out_q.rec.person_id;
		rsp.out_other_fields = out_q.rec.other_fields;
		rsp.last_of_merge    = out_q.last;
	end
endmodule

// ----- rtl/two_run_record_merge_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_run_record_merge_core
// Two-way merge of two sorted record runs held in on-chip record stores.
//
//   port  direction  carries
//   ----  ---------  ------------------------------------------------------
//   req   in         request word: type plus record (names, id, other data)
//   rsp   out        response word: status, record, last-of-merge flag
//
// A pull passes through ST_READ before ST_EMIT, an append goes straight to ST_EMIT;
// ST_READ covers the registered read of both run stores at the head addresses.
// One request is in work at a time; the next is taken while the previous
// response still waits in the output register.
// Reset clears counts and flags; record stores need no clearing.
// Output stalls hold the response; a second result waits until it drains.
// ----------------------------------------------------------------------------
module two_run_record_merge_core #(
	parameter int unsigned RUN_DEPTH  = 32,
	parameter int unsigned NAME_CHARS = 8,
	parameter int unsigned OTHER_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	trrm_req_if.sink    req,
	trrm_rsp_if.source  rsp
);
	import trrm_pkg::*;

	localparam int unsigned AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

	logic          we_a, we_b;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	rec_t          wdata, rdata_a, rdata_b;

	// Sequencer
	trrm_ctrl #(
		.RUN_DEPTH  (RUN_DEPTH),
		.NAME_CHARS (NAME_CHARS),
		.OTHER_BITS (OTHER_BITS),
		.AW         (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.we_a    (we_a),
		.we_b    (we_b),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// First run store
	trrm_run_mem #(
		.DEPTH (RUN_DEPTH),
		.AW    (AW)
	) u_mem_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	// Second run store
	trrm_run_mem #(
		.DEPTH (RUN_DEPTH),
		.AW    (AW)
	) u_mem_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);
endmodule
